FILE: hdl/adif_tag_length_value_tokenizer_defines.svh
// Assertion macros shared by the tokenizer checker.
// No dependencies; included by name where assertions are written.
`ifndef ADIF_TAG_LENGTH_VALUE_TOKENIZER_DEFINES_SVH
`define ADIF_TAG_LENGTH_VALUE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define ADIF_TLV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// Next-cycle implication, disabled while reset is low.
`define ADIF_TLV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`endif

FILE: hdl/adif_tlv_pkg.sv
// Types, codes, constants and helper functions of the ADI tokenizer.
// No dependencies; used by scoped name from the top level, checker and bench.
package adif_tlv_pkg;

    localparam int MAX_HELD_BLANKS_DEF = 63;
    localparam int LENGTH_BITS_DEF     = 16;

    localparam logic [15:0] MAX_FIELD_LENGTH_RST = 16'd32767;
    localparam logic [3:0]  KEY_COUNT_MAX        = 4'd15;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    localparam logic [63:0] KW_VER_TEXT = "ADIF_VER";
    localparam logic [23:0] KW_EOH_TEXT = "EOH";
    localparam logic [23:0] KW_EOR_TEXT = "EOR";
    localparam logic [3:0]  KW_VER_LEN  = 4'd8;
    localparam logic [3:0]  KW_EOH_LEN  = 4'd3;
    localparam logic [3:0]  KW_EOR_LEN  = 4'd3;

    localparam int KW_VER = 0;
    localparam int KW_EOH = 1;
    localparam int KW_EOR = 2;

    typedef enum logic [3:0] {
        PH_START,
        PH_SKIP,
        PH_KEY,
        PH_LEN,
        PH_TYPE,
        PH_CLOSE,
        PH_DATA,
        PH_HALT
    } t_phase;

    typedef enum logic [2:0] {
        KIND_KEY,
        KIND_DATA,
        KIND_FIELD_END,
        KIND_HEADER_END,
        KIND_RECORD_END,
        KIND_STREAM_END,
        KIND_ERROR
    } t_kind;

    typedef enum logic [2:0] {
        ERR_UNKNOWN_TAG,
        ERR_NO_COLON,
        ERR_TOO_LONG,
        ERR_NO_CLOSE,
        ERR_TRUNCATED,
        ERR_EMPTY_RECORD,
        ERR_END_IN_RECORD,
        ERR_END_IN_HEADER
    } t_err;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  char_value;
        logic [7:0]  type_indicator;
        logic        header_field;
        t_err        error_code;
    } t_result;

    function automatic t_result make_result(t_kind kind, logic [7:0] ch,
                                            logic [7:0] ty, logic hdr);
        t_result r;
        r.kind           = kind;
        r.char_value     = ch;
        r.type_indicator = ty;
        r.header_field   = hdr;
        r.error_code     = ERR_UNKNOWN_TAG;
        return r;
    endfunction

    function automatic t_result err_result(t_err code);
        t_result r;
        r.kind           = KIND_ERROR;
        r.char_value     = 8'h00;
        r.type_indicator = 8'h00;
        r.header_field   = 1'b0;
        r.error_code     = code;
        return r;
    endfunction

    function automatic logic is_blank(logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic [3:0] kw_len(int k);
        logic [3:0] len;
        case (k)
            KW_VER:  len = KW_VER_LEN;
            KW_EOH:  len = KW_EOH_LEN;
            default: len = KW_EOR_LEN;
        endcase
        return len;
    endfunction

    // True when the keyword k has letter u at position idx.
    function automatic logic kw_hit(int k, logic [3:0] idx, logic [7:0] u);
        logic hit;
        hit = 1'b0;
        case (k)
            KW_VER: begin
                if (idx < KW_VER_LEN)
                    hit = (KW_VER_TEXT[8 * (7 - idx[2:0]) +: 8] == u);
            end
            KW_EOH: begin
                if (idx < KW_EOH_LEN)
                    hit = (KW_EOH_TEXT[8 * (2 - idx[1:0]) +: 8] == u);
            end
            default: begin
                if (idx < KW_EOR_LEN)
                    hit = (KW_EOR_TEXT[8 * (2 - idx[1:0]) +: 8] == u);
            end
        endcase
        return hit;
    endfunction

endpackage

FILE: hdl/adif_tlv_ifs.sv
// Channel interfaces of the ADI tokenizer: byte input, result output, config write.
// Depends on nothing; payload widths follow the block's field list.
interface adif_tlv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       end_of_stream;

    modport source (output valid, output stream_byte, output end_of_stream, input ready);
    modport sink   (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

interface adif_tlv_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] char_value;
    logic [7:0] type_indicator;
    logic       header_field;
    logic [2:0] error_code;
    logic       last;

    modport source (output valid, output kind, output char_value, output type_indicator,
                    output header_field, output error_code, output last, input ready);
    modport sink   (input valid, input kind, input char_value, input type_indicator,
                    input header_field, input error_code, input last, output ready);
endinterface

interface adif_tlv_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_field_length;

    modport source (output valid, output max_field_length, input ready);
    modport sink   (input valid, input max_field_length, output ready);
endinterface

FILE: hdl/adif_tag_length_value_tokenizer.sv
// A byte's first result is registered and shown in the cycle after its transfer.
// Throughput: one byte per cycle while each byte yields at most one result and
// the output is ready; the result register sends one result per ready cycle, so
// a data byte ending a field gives two results, a key byte after n blanks n + 1.
// Reset: synchronous, active low; clears parser state, restores max length 32767.
module adif_tag_length_value_tokenizer #(
    parameter int MAX_HELD_BLANKS = adif_tlv_pkg::MAX_HELD_BLANKS_DEF,
    parameter int LENGTH_BITS     = adif_tlv_pkg::LENGTH_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    adif_tlv_in_if.sink           i_in,
    adif_tlv_out_if.source        o_out,
    adif_tlv_cfg_if.sink          i_cfg
);

    localparam int HBW = $clog2(MAX_HELD_BLANKS + 1);
    localparam int SW  = ((HBW > 4) ? HBW : 4) + 1;
    localparam int LW  = LENGTH_BITS + 1;
    localparam int MW  = LENGTH_BITS + 4;
    localparam int CW  = (LW > 16) ? LW : 16;

    localparam logic [MW-1:0]  LEN_CAP_M = MW'(1) << LENGTH_BITS;
    localparam logic [LW-1:0]  LEN_CAP   = LW'(1) << LENGTH_BITS;
    localparam logic [HBW-1:0] HELD_MAX  = HBW'(MAX_HELD_BLANKS);

    adif_tlv_pkg::t_phase  r_phase, n_phase;
    logic [HBW-1:0]        r_held, n_held;
    logic [3:0]            r_count, n_count;
    logic [2:0]            r_flags, n_flags;
    logic [LW-1:0]         r_len, n_len;
    logic [7:0]            r_type, n_type;
    logic                  r_inside, n_inside;
    logic                  r_first, n_first;
    logic                  r_rhf, n_rhf;
    logic [15:0]           r_max_len;

    logic [HBW-1:0]        r_blanks, n_blanks;
    logic [1:0]            r_nev, n_nev;
    adif_tlv_pkg::t_result r_ev0, n_ev0;
    adif_tlv_pkg::t_result r_ev1, n_ev1;

    logic                  l_in_xfer;
    logic                  l_out_xfer;
    logic                  l_idle;
    logic                  l_left1;
    logic [7:0]            l_byte;
    logic [7:0]            l_upper;
    logic [2:0]            l_word;
    logic                  l_too_long;
    logic [MW-1:0]         l_len_mul;
    logic [LW-1:0]         l_len_dec;
    logic [SW-1:0]         l_sum;
    logic [3:0]            l_count;
    logic                  l_fe;
    logic                  l_hdr;
    logic [HBW-1:0]        l_blanks;
    logic [1:0]            l_nev;
    adif_tlv_pkg::t_result l_ev0;
    adif_tlv_pkg::t_result l_ev1;
    adif_tlv_pkg::t_result l_head;

    assign l_byte     = i_in.stream_byte;
    assign l_upper    = (l_byte >= adif_tlv_pkg::CH_LC_A && l_byte <= adif_tlv_pkg::CH_LC_Z)
                        ? l_byte - adif_tlv_pkg::CASE_GAP : l_byte;
    assign l_too_long = r_len[LENGTH_BITS] || (CW'(r_len) > CW'(r_max_len));
    assign l_len_mul  = ({3'b000, r_len} << 3) + ({3'b000, r_len} << 1) + MW'(l_byte[3:0]);
    assign l_len_dec  = r_len - LW'(1);
    assign l_sum      = SW'(r_count) + SW'(r_held);

    always_comb begin
        for (int k = 0; k < 3; k++)
            l_word[k] = r_flags[k] && (r_count == adif_tlv_pkg::kw_len(k));
    end

    // Per-byte parser step
    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        n_count  = r_count;
        n_flags  = r_flags;
        n_len    = r_len;
        n_type   = r_type;
        n_inside = r_inside;
        n_first  = r_first;
        n_rhf    = r_rhf;
        l_count  = r_count;
        l_fe     = 1'b0;
        l_hdr    = r_inside;
        l_blanks = '0;
        l_nev    = 2'd0;
        l_ev0    = adif_tlv_pkg::err_result(adif_tlv_pkg::ERR_UNKNOWN_TAG);
        l_ev1    = adif_tlv_pkg::err_result(adif_tlv_pkg::ERR_UNKNOWN_TAG);

        if (l_in_xfer && i_in.end_of_stream) begin
            case (r_phase)
                adif_tlv_pkg::PH_START: begin
                    n_phase = adif_tlv_pkg::PH_HALT;
                    l_nev   = 2'd1;
                    l_ev0   = adif_tlv_pkg::err_result(adif_tlv_pkg::ERR_END_IN_HEADER);
                end
                adif_tlv_pkg::PH_SKIP: begin
                    n_phase = adif_tlv_pkg::PH_HALT;
                    l_nev   = 2'd1;
                    if (r_inside)
                        l_ev0 = adif_tlv_pkg::err_result(adif_tlv_pkg::ERR_END_IN_HEADER);
                    else if (r_rhf)
                        l_ev0 = adif_tlv_pkg::err_result(adif_tlv_pkg::ERR_END_IN_RECORD);
                    else
                        l_ev0 = adif_tlv_pkg::make_result(adif_tlv_pkg::KIND_STREAM_END,
                                                          8'h00, 8'h00, 1'b0);
                end
                adif_tlv_pkg::PH_KEY: begin
                    n_phase = adif_tlv_pkg::PH_HALT;
                    l_nev   = 2'd1;
                    l_ev0   = adif_tlv_pkg::err_result(adif_tlv_pkg::ERR_NO_COLON);
                end
                adif_tlv_pkg::PH_LEN: begin
                    n_phase = adif_tlv_pkg::PH_HALT;
                    l_nev   = 2'd1;
                    l_ev0   = adif_tlv_pkg::err_result(l_too_long
                                  ? adif_tlv_pkg::ERR_TOO_LONG : adif_tlv_pkg::ERR_NO_CLOSE);
                end
                adif_tlv_pkg::PH_TYPE, adif_tlv_pkg::PH_CLOSE: begin
                    n_phase = adif_tlv_pkg::PH_HALT;
                    l_nev   = 2'd1;
                    l_ev0   = adif_tlv_pkg::err_result(adif_tlv_pkg::ERR_NO_CLOSE);
                end
                adif_tlv_pkg::PH_DATA: begin
                    n_phase = adif_tlv_pkg::PH_HALT;
                    l_nev   = 2'd1;
                    l_ev0   = adif_tlv_pkg::err_result(adif_tlv_pkg::ERR_TRUNCATED);
                end
                default: begin
                end
            endcase
        end else if (l_in_xfer) begin
            case (r_phase)
                adif_tlv_pkg::PH_START, adif_tlv_pkg::PH_SKIP: begin
                    if (l_byte == adif_tlv_pkg::CH_LT) begin
                        n_phase = adif_tlv_pkg::PH_KEY;
                        n_held  = '0;
                        n_count = 4'd0;
                        n_flags = 3'b111;
                        n_len   = '0;
                        n_type  = 8'h00;
                    end else if (r_phase == adif_tlv_pkg::PH_START) begin
                        n_inside = 1'b1;
                        n_phase  = adif_tlv_pkg::PH_SKIP;
                    end
                end
                adif_tlv_pkg::PH_KEY: begin
                    if (l_byte == adif_tlv_pkg::CH_COLON) begin
                        n_phase = adif_tlv_pkg::PH_LEN;
                    end else if (l_byte == adif_tlv_pkg::CH_GT) begin
                        n_phase = adif_tlv_pkg::PH_SKIP;
                        l_nev   = 2'd1;
                        if (r_inside) begin
                            if (l_word[adif_tlv_pkg::KW_EOH]) begin
                                n_inside = 1'b0;
                                l_ev0 = adif_tlv_pkg::make_result(
                                    adif_tlv_pkg::KIND_HEADER_END, 8'h00, 8'h00, 1'b0);
                            end else begin
                                n_phase = adif_tlv_pkg::PH_HALT;
                            end
                        end else if (!l_word[adif_tlv_pkg::KW_EOR]) begin
                            n_phase = adif_tlv_pkg::PH_HALT;
                        end else if (!r_rhf) begin
                            n_phase = adif_tlv_pkg::PH_HALT;
                            n_first = 1'b0;
                            l_ev0   = adif_tlv_pkg::err_result(
                                          adif_tlv_pkg::ERR_EMPTY_RECORD);
                        end else begin
                            n_first = 1'b0;
                            n_rhf   = 1'b0;
                            l_ev0   = adif_tlv_pkg::make_result(
                                adif_tlv_pkg::KIND_RECORD_END, 8'h00, 8'h00, 1'b0);
                        end
                    end else if (adif_tlv_pkg::is_blank(l_byte)) begin
                        if (r_count != 4'd0 && r_held < HELD_MAX)
                            n_held = r_held + HBW'(1);
                    end else begin
                        if (r_held != '0) begin
                            l_blanks = r_held;
                            n_flags  = 3'b000;
                            n_held   = '0;
                            l_count  = (l_sum > SW'(adif_tlv_pkg::KEY_COUNT_MAX))
                                       ? adif_tlv_pkg::KEY_COUNT_MAX : l_sum[3:0];
                        end else begin
                            for (int k = 0; k < 3; k++)
                                n_flags[k] = r_flags[k] &&
                                             adif_tlv_pkg::kw_hit(k, r_count, l_upper);
                        end
                        n_count = (l_count < adif_tlv_pkg::KEY_COUNT_MAX)
                                  ? l_count + 4'd1 : l_count;
                        l_nev   = 2'd1;
                        l_ev0   = adif_tlv_pkg::make_result(adif_tlv_pkg::KIND_KEY,
                                                            l_upper, 8'h00, 1'b0);
                    end
                end
                adif_tlv_pkg::PH_LEN: begin
                    if (l_byte >= adif_tlv_pkg::CH_ZERO && l_byte <= adif_tlv_pkg::CH_NINE) begin
                        n_len = (l_len_mul > LEN_CAP_M) ? LEN_CAP : l_len_mul[LW-1:0];
                    end else if (l_too_long) begin
                        n_phase = adif_tlv_pkg::PH_HALT;
                        l_nev   = 2'd1;
                        l_ev0   = adif_tlv_pkg::err_result(adif_tlv_pkg::ERR_TOO_LONG);
                    end else if (l_byte == adif_tlv_pkg::CH_COLON) begin
                        n_phase = adif_tlv_pkg::PH_TYPE;
                    end else if (l_byte == adif_tlv_pkg::CH_GT) begin
                        if (r_len == '0)
                            l_fe = 1'b1;
                        else
                            n_phase = adif_tlv_pkg::PH_DATA;
                    end else begin
                        n_phase = adif_tlv_pkg::PH_HALT;
                        l_nev   = 2'd1;
                        l_ev0   = adif_tlv_pkg::err_result(adif_tlv_pkg::ERR_NO_CLOSE);
                    end
                end
                adif_tlv_pkg::PH_TYPE: begin
                    n_type  = l_byte;
                    n_phase = adif_tlv_pkg::PH_CLOSE;
                end
                adif_tlv_pkg::PH_CLOSE: begin
                    if (l_byte == adif_tlv_pkg::CH_GT) begin
                        if (r_len == '0)
                            l_fe = 1'b1;
                        else
                            n_phase = adif_tlv_pkg::PH_DATA;
                    end else begin
                        n_phase = adif_tlv_pkg::PH_HALT;
                        l_nev   = 2'd1;
                        l_ev0   = adif_tlv_pkg::err_result(adif_tlv_pkg::ERR_NO_CLOSE);
                    end
                end
                adif_tlv_pkg::PH_DATA: begin
                    l_nev = 2'd1;
                    l_ev0 = adif_tlv_pkg::make_result(adif_tlv_pkg::KIND_DATA,
                                                      l_byte, 8'h00, 1'b0);
                    n_len = l_len_dec;
                    if (l_len_dec == '0)
                        l_fe = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (l_fe) begin
            n_phase = adif_tlv_pkg::PH_SKIP;
            if (!r_inside) begin
                if (r_first && l_word[adif_tlv_pkg::KW_VER]) begin
                    n_inside = 1'b1;
                    l_hdr    = 1'b1;
                end else begin
                    n_rhf = 1'b1;
                end
                n_first = 1'b0;
            end
            if (l_nev == 2'd0)
                l_ev0 = adif_tlv_pkg::make_result(adif_tlv_pkg::KIND_FIELD_END,
                                                  8'h00, r_type, l_hdr);
            else
                l_ev1 = adif_tlv_pkg::make_result(adif_tlv_pkg::KIND_FIELD_END,
                                                  8'h00, r_type, l_hdr);
            l_nev = l_nev + 2'd1;
        end
    end

    // Result register: held blanks first, then up to two events
    assign l_idle     = (r_blanks == '0) && (r_nev == 2'd0);
    assign l_left1    = (r_blanks == '0) && (r_nev == 2'd1);
    assign i_in.ready = i_rst_n && (l_idle || (l_left1 && o_out.ready));
    assign l_in_xfer  = i_in.valid && i_in.ready;
    assign l_out_xfer = o_out.valid && o_out.ready;

    always_comb begin
        n_blanks = r_blanks;
        n_nev    = r_nev;
        n_ev0    = r_ev0;
        n_ev1    = r_ev1;
        if (l_in_xfer) begin
            n_blanks = l_blanks;
            n_nev    = l_nev;
            n_ev0    = l_ev0;
            n_ev1    = l_ev1;
        end else if (l_out_xfer) begin
            if (r_blanks != '0) begin
                n_blanks = r_blanks - HBW'(1);
            end else begin
                n_ev0 = r_ev1;
                n_nev = r_nev - 2'd1;
            end
        end
    end

    assign l_head = (r_blanks != '0)
                    ? adif_tlv_pkg::make_result(adif_tlv_pkg::KIND_KEY,
                                                adif_tlv_pkg::CH_SPACE, 8'h00, 1'b0)
                    : r_ev0;

    assign o_out.valid          = !l_idle;
    assign o_out.kind           = l_head.kind;
    assign o_out.char_value     = l_head.char_value;
    assign o_out.type_indicator = l_head.type_indicator;
    assign o_out.header_field   = l_head.header_field;
    assign o_out.error_code     = l_head.error_code;
    assign o_out.last           = l_left1;

    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= adif_tlv_pkg::PH_START;
            r_held    <= '0;
            r_count   <= 4'd0;
            r_flags   <= 3'b111;
            r_len     <= '0;
            r_type    <= 8'h00;
            r_inside  <= 1'b0;
            r_first   <= 1'b1;
            r_rhf     <= 1'b0;
            r_max_len <= adif_tlv_pkg::MAX_FIELD_LENGTH_RST;
            r_blanks  <= '0;
            r_nev     <= 2'd0;
        end else begin
            r_phase  <= n_phase;
            r_held   <= n_held;
            r_count  <= n_count;
            r_flags  <= n_flags;
            r_len    <= n_len;
            r_type   <= n_type;
            r_inside <= n_inside;
            r_first  <= n_first;
            r_rhf    <= n_rhf;
            r_blanks <= n_blanks;
            r_nev    <= n_nev;
            if (i_cfg.valid && i_cfg.ready)
                r_max_len <= i_cfg.max_field_length;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev0 <= n_ev0;
        r_ev1 <= n_ev1;
    end

endmodule

FILE: hdl/adif_tlv_checker.sv
// Port-level checks on the tokenizer result channel, bound to the top level.
// Depends on adif_tlv_pkg and the assertion macros header.
`include "adif_tag_length_value_tokenizer_defines.svh"

module adif_tlv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_out_kind,
    input logic [7:0] i_out_char_value,
    input logic       i_out_last
);

    `ADIF_TLV_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_kind) && $stable(i_out_char_value) && $stable(i_out_last))
    `ADIF_TLV_ASSERT_IMP(a_stop_is_last, i_clk, i_rst_n, i_out_valid && (i_out_kind == adif_tlv_pkg::KIND_ERROR || i_out_kind == adif_tlv_pkg::KIND_STREAM_END), i_out_last)
    `ADIF_TLV_ASSERT_NXT(a_silent_after_stop, i_clk, i_rst_n, i_out_valid && i_out_ready && (i_out_kind == adif_tlv_pkg::KIND_ERROR || i_out_kind == adif_tlv_pkg::KIND_STREAM_END), !i_out_valid)
    `ADIF_TLV_ASSERT_IMP(a_char_zero, i_clk, i_rst_n, i_out_valid && i_out_kind != adif_tlv_pkg::KIND_KEY && i_out_kind != adif_tlv_pkg::KIND_DATA, i_out_char_value == 8'h00)

endmodule

bind adif_tag_length_value_tokenizer adif_tlv_checker u_adif_tlv_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_kind       (o_out.kind),
    .i_out_char_value (o_out.char_value),
    .i_out_last       (o_out.last)
);

FILE: bench/tb_adif_tag_length_value_tokenizer.sv
// Self-checking bench for the ADI tag/length/value tokenizer: byte stream in, token stream out.
// Depends on adif_tlv_pkg and the channel interfaces; a scoreboard class predicts every token.
// Stimulus is one well-formed log per run with random content, ending in a random terminal case.
module tb_adif_tag_length_value_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        adif_tlv_pkg::t_kind kind;
        logic [7:0]          char_value;
        logic [7:0]          type_indicator;
        logic                header_field;
        adif_tlv_pkg::t_err  error_code;
        logic                last;
    } t_token;

    class t_token_scoreboard;
        t_token               expected_tokens[$];
        int unsigned          mismatches;
        adif_tlv_pkg::t_phase phase;
        logic [5:0]           held_blanks;
        logic [3:0]           key_count;
        logic [2:0]           key_match;
        logic [16:0]          remaining;
        logic [7:0]           held_type;
        logic                 in_header;
        logic                 first_tag_open;
        logic                 record_open;
        logic                 halted;
        logic [15:0]          max_length;
        string                keyword[3];

        function new();
            keyword        = '{"ADIF_VER", "EOH", "EOR"};
            phase          = adif_tlv_pkg::PH_START;
            held_blanks    = '0;
            key_count      = '0;
            key_match      = '1;
            remaining      = '0;
            held_type      = '0;
            in_header      = 1'b0;
            first_tag_open = 1'b1;
            record_open    = 1'b0;
            halted         = 1'b0;
            max_length     = 16'd32767;
            mismatches     = 0;
        endfunction

        function void push(adif_tlv_pkg::t_kind kind, logic [7:0] ch, logic [7:0] ty,
                           logic hdr, adif_tlv_pkg::t_err code);
            t_token t;
            t.kind           = kind;
            t.char_value     = ch;
            t.type_indicator = ty;
            t.header_field   = hdr;
            t.error_code     = code;
            t.last           = 1'b0;
            expected_tokens.push_back(t);
        endfunction

        function void halt_on(adif_tlv_pkg::t_err code);
            halted = 1'b1;
            phase  = adif_tlv_pkg::PH_HALT;
            push(adif_tlv_pkg::KIND_ERROR, 8'h00, 8'h00, 1'b0, code);
        endfunction

        function logic blank(logic [7:0] b);
            return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
        endfunction

        function logic word_is(int k);
            return key_match[k] && key_count == keyword[k].len();
        endfunction

        function logic too_long();
            return remaining[16] || remaining > {1'b0, max_length};
        endfunction

        function void open_tag();
            phase       = adif_tlv_pkg::PH_KEY;
            held_blanks = '0;
            key_count   = '0;
            key_match   = '1;
            remaining   = '0;
            held_type   = '0;
        endfunction

        function void close_field();
            logic hdr;
            hdr = in_header;
            if (!in_header) begin
                if (first_tag_open && word_is(adif_tlv_pkg::KW_VER)) begin
                    in_header = 1'b1;
                    hdr       = 1'b1;
                end else begin
                    record_open = 1'b1;
                end
                first_tag_open = 1'b0;
            end
            phase = adif_tlv_pkg::PH_SKIP;
            push(adif_tlv_pkg::KIND_FIELD_END, 8'h00, held_type, hdr,
                 adif_tlv_pkg::ERR_UNKNOWN_TAG);
        endfunction

        function void begin_data();
            if (remaining == 0)
                close_field();
            else
                phase = adif_tlv_pkg::PH_DATA;
        endfunction

        function void key_char_in(logic [7:0] b);
            logic [7:0] u;
            logic [7:0] want;
            int         total;
            u = (b >= "a" && b <= "z") ? b - 8'h20 : b;
            if (held_blanks != 0) begin
                repeat (held_blanks)
                    push(adif_tlv_pkg::KIND_KEY, 8'h20, 8'h00, 1'b0,
                         adif_tlv_pkg::ERR_UNKNOWN_TAG);
                key_match   = '0;
                total       = key_count + held_blanks;
                key_count   = (total > 15) ? 4'd15 : total[3:0];
                held_blanks = '0;
            end
            for (int k = 0; k < 3; k++) begin
                want = (key_count < keyword[k].len()) ? keyword[k][key_count] : 8'h00;
                if (key_count >= keyword[k].len() || want != u)
                    key_match[k] = 1'b0;
            end
            if (key_count != 4'd15)
                key_count++;
            push(adif_tlv_pkg::KIND_KEY, u, 8'h00, 1'b0, adif_tlv_pkg::ERR_UNKNOWN_TAG);
        endfunction

        function void tag_closed();
            phase = adif_tlv_pkg::PH_SKIP;
            if (in_header) begin
                if (word_is(adif_tlv_pkg::KW_EOH)) begin
                    in_header = 1'b0;
                    push(adif_tlv_pkg::KIND_HEADER_END, 8'h00, 8'h00, 1'b0,
                         adif_tlv_pkg::ERR_UNKNOWN_TAG);
                end else begin
                    halt_on(adif_tlv_pkg::ERR_UNKNOWN_TAG);
                end
            end else if (!word_is(adif_tlv_pkg::KW_EOR)) begin
                halt_on(adif_tlv_pkg::ERR_UNKNOWN_TAG);
            end else begin
                first_tag_open = 1'b0;
                if (!record_open) begin
                    halt_on(adif_tlv_pkg::ERR_EMPTY_RECORD);
                end else begin
                    record_open = 1'b0;
                    push(adif_tlv_pkg::KIND_RECORD_END, 8'h00, 8'h00, 1'b0,
                         adif_tlv_pkg::ERR_UNKNOWN_TAG);
                end
            end
        endfunction

        function void scan(logic [7:0] b);
            int v;
            case (phase)
                adif_tlv_pkg::PH_START: begin
                    if (b == "<") begin
                        open_tag();
                    end else begin
                        in_header = 1'b1;
                        phase     = adif_tlv_pkg::PH_SKIP;
                    end
                end
                adif_tlv_pkg::PH_SKIP: begin
                    if (b == "<")
                        open_tag();
                end
                adif_tlv_pkg::PH_KEY: begin
                    if (b == ":")
                        phase = adif_tlv_pkg::PH_LEN;
                    else if (b == ">")
                        tag_closed();
                    else if (blank(b)) begin
                        if (key_count != 0 && held_blanks < adif_tlv_pkg::MAX_HELD_BLANKS_DEF)
                            held_blanks++;
                    end else
                        key_char_in(b);
                end
                adif_tlv_pkg::PH_LEN: begin
                    if (b >= "0" && b <= "9") begin
                        v = remaining * 10 + (b - 8'h30);
                        if (v > (1 << adif_tlv_pkg::LENGTH_BITS_DEF))
                            v = 1 << adif_tlv_pkg::LENGTH_BITS_DEF;
                        remaining = v[16:0];
                    end else if (too_long())
                        halt_on(adif_tlv_pkg::ERR_TOO_LONG);
                    else if (b == ":")
                        phase = adif_tlv_pkg::PH_TYPE;
                    else if (b == ">")
                        begin_data();
                    else
                        halt_on(adif_tlv_pkg::ERR_NO_CLOSE);
                end
                adif_tlv_pkg::PH_TYPE: begin
                    held_type = b;
                    phase     = adif_tlv_pkg::PH_CLOSE;
                end
                adif_tlv_pkg::PH_CLOSE: begin
                    if (b == ">")
                        begin_data();
                    else
                        halt_on(adif_tlv_pkg::ERR_NO_CLOSE);
                end
                adif_tlv_pkg::PH_DATA: begin
                    push(adif_tlv_pkg::KIND_DATA, b, 8'h00, 1'b0, adif_tlv_pkg::ERR_UNKNOWN_TAG);
                    if (remaining != 0)
                        remaining--;
                    if (remaining == 0)
                        close_field();
                end
                default: ;
            endcase
        endfunction

        function void end_of_input();
            case (phase)
                adif_tlv_pkg::PH_START: halt_on(adif_tlv_pkg::ERR_END_IN_HEADER);
                adif_tlv_pkg::PH_SKIP: begin
                    if (in_header)
                        halt_on(adif_tlv_pkg::ERR_END_IN_HEADER);
                    else if (record_open)
                        halt_on(adif_tlv_pkg::ERR_END_IN_RECORD);
                    else begin
                        halted = 1'b1;
                        phase  = adif_tlv_pkg::PH_HALT;
                        push(adif_tlv_pkg::KIND_STREAM_END, 8'h00, 8'h00, 1'b0,
                             adif_tlv_pkg::ERR_UNKNOWN_TAG);
                    end
                end
                adif_tlv_pkg::PH_KEY: halt_on(adif_tlv_pkg::ERR_NO_COLON);
                adif_tlv_pkg::PH_LEN:
                    halt_on(too_long() ? adif_tlv_pkg::ERR_TOO_LONG : adif_tlv_pkg::ERR_NO_CLOSE);
                adif_tlv_pkg::PH_TYPE, adif_tlv_pkg::PH_CLOSE:
                    halt_on(adif_tlv_pkg::ERR_NO_CLOSE);
                adif_tlv_pkg::PH_DATA: halt_on(adif_tlv_pkg::ERR_TRUNCATED);
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic eos);
            int     start_count;
            t_token t;
            if (halted)
                return;
            start_count = expected_tokens.size();
            if (eos)
                end_of_input();
            else
                scan(b);
            if (expected_tokens.size() > start_count) begin
                t      = expected_tokens.pop_back();
                t.last = 1'b1;
                expected_tokens.push_back(t);
            end
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void check_token(logic [2:0] kind, logic [7:0] ch, logic [7:0] ty, logic hdr,
                                  logic [2:0] code, logic last);
            t_token w;
            if (expected_tokens.size() == 0) begin
                report($sformatf("unexpected token: kind %0d char %02h type %02h err %0d",
                                 kind, ch, ty, code));
                return;
            end
            w = expected_tokens.pop_front();
            if (kind !== w.kind || ch !== w.char_value || ty !== w.type_indicator ||
                hdr !== w.header_field || code !== w.error_code || last !== w.last)
                report($sformatf({"token mismatch: expected kind %0d char %02h type %02h ",
                                  "hdr %0b err %0d last %0b, got kind %0d char %02h ",
                                  "type %02h hdr %0b err %0d last %0b"},
                                 w.kind, w.char_value, w.type_indicator, w.header_field,
                                 w.error_code, w.last, kind, ch, ty, hdr, code, last));
        endfunction

        function int waiting();
            return expected_tokens.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   steady;
    int   sent;

    adif_tlv_in_if  in_if ();
    adif_tlv_out_if out_if ();
    adif_tlv_cfg_if cfg_if ();

    t_token_scoreboard board = new();

    adif_tag_length_value_tokenizer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #5ns i_clk = ~i_clk;

    function automatic logic [7:0] blank_char();
        return $urandom_range(1) ? 8'h20 : 8'($urandom_range(13, 9));
    endfunction

    function automatic logic [7:0] key_char();
        logic [7:0] c;
        case ($urandom_range(5))
            0, 1:    c = 8'($urandom_range(8'h5A, 8'h41));
            2:       c = 8'($urandom_range(8'h7A, 8'h61));
            3:       c = 8'($urandom_range(8'h39, 8'h30));
            4:       c = "_";
            default: begin
                do
                    c = 8'($urandom_range(255));
                while (c == ":" || c == ">" || board.blank(c));
            end
        endcase
        return c;
    endfunction

    task automatic send_item(logic [7:0] b, logic eos);
        while (!steady && $urandom_range(99) < 38) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.stream_byte   <= b;
        in_if.end_of_stream <= eos;
        do
            @(posedge i_clk);
        while (in_if.ready !== 1'b1);
        board.note_byte(b, eos);
        sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic send_blanks(int n);
        repeat (n) send_item(blank_char(), 1'b0);
    endtask

    task automatic send_key();
        int n;
        n = $urandom_range(9);
        if ($urandom_range(9) == 0)
            send_blanks($urandom_range(1, 3));
        for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(7) == 0)
                send_blanks(($urandom_range(14) == 0) ? $urandom_range(70, 60)
                                                      : $urandom_range(3, 1));
            send_item(key_char(), 1'b0);
        end
        if ($urandom_range(7) == 0)
            send_blanks($urandom_range(2, 1));
    endtask

    task automatic send_length(int len);
        if (len == 0 && $urandom_range(2) == 0)
            return;
        repeat (($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0) send_item("0", 1'b0);
        send_text($sformatf("%0d", len));
    endtask

    task automatic send_field(int lim);
        int len;
        len = ($urandom_range(3) == 0) ? lim : $urandom_range(lim, 0);
        send_item("<", 1'b0);
        send_key();
        send_item(":", 1'b0);
        send_length(len);
        if ($urandom_range(99) < 40) begin
            send_item(":", 1'b0);
            send_item(8'($urandom_range(255)), 1'b0);
        end
        send_item(">", 1'b0);
        repeat (len) send_item(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic send_marker(string word);
        logic [7:0] c;
        send_item("<", 1'b0);
        if ($urandom_range(5) == 0)
            send_blanks(1);
        for (int i = 0; i < word.len(); i++) begin
            c = word[i];
            if ($urandom_range(1))
                c = c | 8'h20;
            send_item(c, 1'b0);
        end
        if ($urandom_range(5) == 0)
            send_blanks($urandom_range(2, 1));
        send_item(">", 1'b0);
    endtask

    task automatic send_junk();
        logic [7:0] c;
        repeat ($urandom_range(4, 1)) begin
            do
                c = 8'($urandom_range(255));
            while (c == "<");
            send_item(c, 1'b0);
        end
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (board.waiting() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max(logic [15:0] v);
        cfg_if.valid            <= 1'b1;
        cfg_if.max_field_length <= v;
        do
            @(posedge i_clk);
        while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        board.max_length = v;
    endtask

    task automatic random_stream(int count, int cap);
        int stop_at;
        int lim;
        stop_at = sent + count;
        while (sent < stop_at) begin
            lim = (board.max_length < cap) ? board.max_length : cap;
            if ($urandom_range(4) == 0)
                send_junk();
            if (board.in_header) begin
                if ($urandom_range(3) == 0)
                    send_marker("EOH");
                else
                    send_field(lim);
            end else if (board.record_open && $urandom_range(2) == 0)
                send_marker("EOR");
            else
                send_field(lim);
            if ($urandom_range(39) == 0)
                drain();
        end
    endtask

    task automatic finish_stream();
        case ($urandom_range(9))
            0: begin
                if (board.record_open)
                    send_marker("EOR");
            end
            1: send_field(4);
            2: send_text("<ab");
            3: send_text($urandom_range(1) ? "<ab:3" : "<ab:999999");
            4: begin
                send_text("<ab:");
                send_text($sformatf("%0d", int'(board.max_length) + 1));
                send_item(">", 1'b0);
            end
            5: send_text("<ab:1x");
            6: send_text("<ab:5>ab");
            7: begin
                if ($urandom_range(1))
                    send_text("<FOO>");
                else
                    send_marker("EOH");
            end
            8: begin
                if (board.record_open)
                    send_marker("EOR");
                send_marker("EOR");
            end
            default: send_text("<ab:1:T");
        endcase
        if (!board.halted)
            send_item(8'($urandom_range(255)), 1'b1);
        repeat (3) send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
                board.check_token(out_if.kind, out_if.char_value, out_if.type_indicator,
                                  out_if.header_field, out_if.error_code, out_if.last);
            out_if.ready <= steady || ($urandom_range(99) >= 38);
        end
    end

    initial begin
        int mode;
        i_rst_n                 <= 1'b0;
        in_if.valid             <= 1'b0;
        in_if.stream_byte       <= 8'h00;
        in_if.end_of_stream     <= 1'b0;
        cfg_if.valid            <= 1'b0;
        cfg_if.max_field_length <= 16'h0000;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        mode = $urandom_range(2);
        if (mode == 1)
            send_text("v\n<PROGRAMID:2:S>tb<EOH>");
        else if (mode == 2)
            send_text("<Adif_Ver:5>3.1.4<EOH>");
        send_text("<e o:2:");
        send_item(8'hFF, 1'b0);
        send_item(">", 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("<eor >< K:><EOR>");

        drain();
        write_max(16'hFFFF);
        random_stream(120, 20);

        drain();
        write_max(16'h0000);
        random_stream(55, 0);

        drain();
        write_max(16'($urandom_range(12, 1)));
        steady = 1'b1;
        random_stream(45, 12);
        steady = 1'b0;
        random_stream(55, 12);

        drain();
        write_max(16'($urandom_range(65534, 13)));
        random_stream(80, 24);

        finish_stream();
        drain();
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0 && board.waiting() == 0)
            $display("adif_tag_length_value_tokenizer verification clean");
        else
            $display("adif_tag_length_value_tokenizer verification failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("adif_tag_length_value_tokenizer verification failed");
        $finish;
    end

endmodule

FILE: adif_tag_length_value_tokenizer.f
+incdir+hdl
hdl/adif_tlv_pkg.sv
hdl/adif_tlv_ifs.sv
hdl/adif_tag_length_value_tokenizer.sv
hdl/adif_tlv_checker.sv
bench/tb_adif_tag_length_value_tokenizer.sv
